>>> hdl/rte_pkg.sv
// ----------------------------------------------------------------------------
// rte_pkg
// Shared constants and helpers for the clock-byte to epoch seconds converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rte_pkg;

    localparam int BYTE_W   = 8;
    localparam int NUM_IN   = 7;
    localparam int IN_W     = BYTE_W * NUM_IN;
    localparam int OUT_W    = 32;
    localparam int YEAR_W   = 15;
    localparam int TOD_W    = 20;
    localparam int QUOT_W   = 9;
    localparam int MDAY_W   = 9;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BINARY_DATA = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOUR_24     = 1'd1;

    localparam int PM_BIT = 7;

    localparam logic [BYTE_W-1:0] HOUR_NOON   = 8'd12;
    localparam logic [BYTE_W-1:0] LAST_MONTH  = 8'd12;
    localparam logic [3:0]        FEB         = 4'd2;

    localparam logic [YEAR_W-1:0] YEARS_PER_CENTURY = 15'd100;
    localparam logic [TOD_W-1:0]  SEC_PER_HOUR      = 20'd3600;
    localparam logic [TOD_W-1:0]  SEC_PER_MIN       = 20'd60;
    localparam logic [OUT_W-1:0]  SEC_PER_DAY       = 32'd86400;
    localparam logic [OUT_W-1:0]  DAYS_PER_YEAR     = 32'd365;
    // day count of 1970-01-01 under the same rule
    localparam logic [OUT_W-1:0]  EPOCH_DAYS        = 32'd719162;

    // y / 100 as (y * 5243) >> 19, exact for y below 43690
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = 28;
    localparam logic [PROD_W-1:0] RECIP_100 = 28'd5243;

    // packed BCD or binary byte to value
    function automatic logic [BYTE_W-1:0] byte_decode(input logic [BYTE_W-1:0] b,
                                                      input logic binary);
        logic [BYTE_W-1:0] hi;
        logic [BYTE_W-1:0] lo;
        hi = {4'b0, b[7:4]};
        lo = {4'b0, b[3:0]};
        if (binary)
            return b;
        else
            return (hi << 3) + (hi << 1) + lo;
    endfunction

    // days in the months before month m, month already clamped to 0..12
    function automatic logic [MDAY_W-1:0] month_start(input logic [3:0] m);
        logic [MDAY_W-1:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

>>> hdl/rtc_time_to_epoch_seconds_core.sv
// ----------------------------------------------------------------------------
// rtc_time_to_epoch_seconds_core
// Converts a set of raw clock register bytes into seconds since 1970-01-01.
// ----------------------------------------------------------------------------
// pipeline: each accepted item passes through the stages in order to m_tvalid
// throughput: one item per cycle while m_tready is high; each stage holds
//   only while the one after it is full and stalled, so bubbles close up under back-pressure
// reset: clears all stage valid bits, binary_data to 0, hour_24 to 1
`default_nettype none

module rtc_time_to_epoch_seconds_core
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [rte_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic                            cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // raw_second, raw_minute, raw_hour, raw_day, raw_month, raw_year,
    // raw_century, 8 bits each from bit 0 up
    input  wire logic [rte_pkg::IN_W-1:0]        s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // epoch_seconds
    output logic [rte_pkg::OUT_W-1:0]            m_tdata
);

    import rte_pkg::*;

    localparam int NSTG = 7;

    logic binary_data_reg;
    logic hour_24_reg;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] stg_en;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            binary_data_reg <= 1'b0;
            hour_24_reg     <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BINARY_DATA: binary_data_reg <= cfg_data;
                CFG_HOUR_24:     hour_24_reg     <= cfg_data;
                default:         ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    always_comb
    begin
        stg_en[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int k = NSTG - 2; k >= 0; k--)
            stg_en[k] = !vld_reg[k] || stg_en[k+1];
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (stg_en[0])
            vld_next[0] = s_tvalid;
        for (int k = 1; k < NSTG; k++)
            if (stg_en[k])
                vld_next[k] = vld_reg[k-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign s_tready = stg_en[0];
    assign m_tvalid = vld_reg[NSTG-1];

    // ---------------- stage 1: byte decode ----------------
    logic [BYTE_W-1:0] sec1_next, min1_next, hr1_next, day1_next;
    logic [BYTE_W-1:0] mon1_next, yr1_next, cen1_next;
    logic [BYTE_W-1:0] sec1_reg, min1_reg, hr1_reg, day1_reg;
    logic [BYTE_W-1:0] mon1_reg, yr1_reg, cen1_reg;
    logic [BYTE_W-1:0] hr_raw;
    logic [BYTE_W-1:0] hr12;

    always_comb
    begin
        sec1_next = byte_decode(s_tdata[7:0],   binary_data_reg);
        min1_next = byte_decode(s_tdata[15:8],  binary_data_reg);
        day1_next = byte_decode(s_tdata[31:24], binary_data_reg);
        mon1_next = byte_decode(s_tdata[39:32], binary_data_reg);
        yr1_next  = byte_decode(s_tdata[47:40], binary_data_reg);
        cen1_next = byte_decode(s_tdata[55:48], binary_data_reg);
        hr_raw    = s_tdata[23:16];
        // 12-hour byte: pm flag stripped before decode
        hr12      = byte_decode({1'b0, hr_raw[PM_BIT-1:0]}, binary_data_reg);
        if (hour_24_reg)
            hr1_next = byte_decode(hr_raw, binary_data_reg);
        else if (hr_raw[PM_BIT])
            hr1_next = (hr12 == HOUR_NOON) ? HOUR_NOON : hr12 + HOUR_NOON;
        else
            hr1_next = (hr12 == HOUR_NOON) ? '0 : hr12;
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[0])
        begin
            sec1_reg <= sec1_next;
            min1_reg <= min1_next;
            hr1_reg  <= hr1_next;
            day1_reg <= day1_next;
            mon1_reg <= mon1_next;
            yr1_reg  <= yr1_next;
            cen1_reg <= cen1_next;
        end
    end

    // ---------------- stage 2: full year, time of day ----------------
    logic [YEAR_W-1:0] year2_next, year2_reg;
    logic [TOD_W-1:0]  tod2_next, tod2_reg;
    logic [BYTE_W-1:0] day2_reg, mon2_reg;

    assign year2_next = YEAR_W'(cen1_reg) * YEARS_PER_CENTURY + YEAR_W'(yr1_reg);
    assign tod2_next  = TOD_W'(hr1_reg) * SEC_PER_HOUR + TOD_W'(min1_reg) * SEC_PER_MIN
                      + TOD_W'(sec1_reg);

    always_ff @(posedge clk)
    begin
        if (stg_en[1])
        begin
            year2_reg <= year2_next;
            tod2_reg  <= tod2_next;
            day2_reg  <= day1_reg;
            mon2_reg  <= mon1_reg;
        end
    end

    // ---------------- stage 3: century quotients ----------------
    logic [YEAR_W-1:0] y13_next, year3_reg, y13_reg;
    logic [PROD_W-1:0] py_prod, py1_prod;
    logic [QUOT_W-1:0] q100y3_reg, q100y13_reg;
    logic [TOD_W-1:0]  tod3_reg;
    logic [BYTE_W-1:0] day3_reg, mon3_reg;

    assign y13_next = year2_reg - YEAR_W'(1);
    assign py_prod  = PROD_W'(year2_reg) * RECIP_100;
    assign py1_prod = PROD_W'(y13_next) * RECIP_100;

    always_ff @(posedge clk)
    begin
        if (stg_en[2])
        begin
            year3_reg   <= year2_reg;
            y13_reg     <= y13_next;
            q100y3_reg  <= py_prod[RECIP_SHIFT +: QUOT_W];
            q100y13_reg <= py1_prod[RECIP_SHIFT +: QUOT_W];
            tod3_reg    <= tod2_reg;
            day3_reg    <= day2_reg;
            mon3_reg    <= mon2_reg;
        end
    end

    // ---------------- stage 4: year, month and day terms ----------------
    logic              is_cent;
    logic              leap;
    logic [3:0]        mon_cl;
    logic [OUT_W-1:0]  yterm4_next, yterm4_reg;
    logic [MDAY_W-1:0] mterm4_next, mterm4_reg;
    logic [OUT_W-1:0]  dterm4_next, dterm4_reg;
    logic [TOD_W-1:0]  tod4_reg;

    always_comb
    begin
        is_cent = (YEAR_W'(q100y3_reg) * YEARS_PER_CENTURY) == year3_reg;
        leap    = (year3_reg[1:0] == 2'b00 && !is_cent)
               || (is_cent && q100y3_reg[1:0] == 2'b00);
        mon_cl  = (mon3_reg > LAST_MONTH) ? LAST_MONTH[3:0] : mon3_reg[3:0];
        // year zero: one year back, no leap-day corrections
        if (year3_reg == '0)
            yterm4_next = '0 - DAYS_PER_YEAR;
        else
            yterm4_next = OUT_W'(y13_reg) * DAYS_PER_YEAR + OUT_W'(y13_reg >> 2)
                        - OUT_W'(q100y13_reg) + OUT_W'(q100y13_reg >> 2);
        mterm4_next = month_start(mon_cl) + MDAY_W'(leap && (mon_cl > FEB));
        dterm4_next = OUT_W'(day3_reg) - OUT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[3])
        begin
            yterm4_reg <= yterm4_next;
            mterm4_reg <= mterm4_next;
            dterm4_reg <= dterm4_next;
            tod4_reg   <= tod3_reg;
        end
    end

    // ---------------- stage 5: days since epoch ----------------
    logic [OUT_W-1:0] days5_next, days5_reg;
    logic [TOD_W-1:0] tod5_reg;

    assign days5_next = yterm4_reg + OUT_W'(mterm4_reg) + dterm4_reg - EPOCH_DAYS;

    always_ff @(posedge clk)
    begin
        if (stg_en[4])
        begin
            days5_reg <= days5_next;
            tod5_reg  <= tod4_reg;
        end
    end

    // ---------------- stage 6: days to seconds ----------------
    logic [OUT_W-1:0] dsec6_next, dsec6_reg;
    logic [TOD_W-1:0] tod6_reg;

    assign dsec6_next = days5_reg * SEC_PER_DAY;

    always_ff @(posedge clk)
    begin
        if (stg_en[5])
        begin
            dsec6_reg <= dsec6_next;
            tod6_reg  <= tod5_reg;
        end
    end

    // ---------------- stage 7: output register ----------------
    logic [OUT_W-1:0] epoch7_next, epoch7_reg;

    assign epoch7_next = dsec6_reg + OUT_W'(tod6_reg);

    always_ff @(posedge clk)
    begin
        if (stg_en[6])
            epoch7_reg <= epoch7_next;
    end

    assign m_tdata = epoch7_reg;

`ifndef SYNTHESIS
    // input only held back when every stage is occupied
    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (vld_reg == {NSTG{1'b1}}))
        else $error("input stalled while a stage is empty");

    // a stalled middle stage keeps its item
    a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[3] && !stg_en[3]) |=>
            (vld_reg[3] && $stable(yterm4_reg) && $stable(dterm4_reg)))
        else $error("stalled stage lost its item");

    // reciprocal quotient stays exact over the year range
    a_q100: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] |->
            ((16'(q100y3_reg) * 16'd100) <= 16'(year3_reg))
            && ((16'(year3_reg) - 16'(q100y3_reg) * 16'd100) < 16'd100))
        else $error("century quotient out of range");
`endif

endmodule

`default_nettype wire

>>> test/tb_rtc_time_to_epoch_seconds_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rtc_time_to_epoch_seconds_core
// Drives sets of raw clock register bytes through the converter under every
// combination of BCD/binary and 12/24-hour mode, with random idling on both
// stream sides, and compares each epoch seconds item against a local model.
// ----------------------------------------------------------------------------

module tb_rtc_time_to_epoch_seconds_core;

    import rte_pkg::*;

    // field order follows s_tdata, raw_second in the lowest byte
    typedef struct packed {
        logic [7:0] century;
        logic [7:0] year;
        logic [7:0] month;
        logic [7:0] day;
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
    } clock_bytes_t;

    class epoch_scoreboard;
        logic [OUT_W-1:0] expected_secs[$];
        bit               binary_mode  = 1'b0;
        bit               hour_24_mode = 1'b1;
        int               errors       = 0;

        task report(input string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function logic [31:0] byte_value(input logic [7:0] b);
            if (binary_mode)
                return 32'(b);
            return 32'(b[7:4]) * 32'd10 + 32'(b[3:0]);
        endfunction

        function logic [31:0] hour_value(input logic [7:0] b);
            logic [31:0] h;
            if (hour_24_mode)
                return byte_value(b);
            h = byte_value({1'b0, b[6:0]});
            if (b[7])
                return (h == 32'd12) ? 32'd12 : h + 32'd12;
            return (h == 32'd12) ? 32'd0 : h;
        endfunction

        function logic [31:0] month_length(input int m);
            case (m)
                2:            return 32'd28;
                4, 6, 9, 11:  return 32'd30;
                default:      return 32'd31;
            endcase
        endfunction

        // days since 0001-01-01 under the 4/100/400 rule, wrapping at 32 bits
        function logic [31:0] day_number(input logic [31:0] yr, input logic [31:0] mon,
                                         input logic [31:0] dom);
            bit          leap;
            logic [31:0] total;
            logic [31:0] y1;
            leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
            if (mon > 32'd12)
                mon = 32'd12;
            total = 32'd0;
            for (int m = 1; m < mon; m++)
            begin
                total += month_length(m);
                if (m == 2 && leap)
                    total += 32'd1;
            end
            total += dom - 32'd1;
            if (yr == 32'd0)
                total -= 32'd365;
            else
            begin
                y1 = yr - 32'd1;
                total += 32'd365 * y1 + y1 / 32'd4 - y1 / 32'd100 + y1 / 32'd400;
            end
            return total;
        endfunction

        function logic [OUT_W-1:0] epoch_seconds_of(input clock_bytes_t b);
            logic [31:0] yr;
            logic [31:0] days;
            yr   = byte_value(b.century) * 32'd100 + byte_value(b.year);
            days = day_number(yr, byte_value(b.month), byte_value(b.day))
                   - day_number(32'd1970, 32'd1, 32'd1);
            return days * 32'd86400 + hour_value(b.hour) * 32'd3600
                   + byte_value(b.minute) * 32'd60 + byte_value(b.second);
        endfunction

        function void note_item(input clock_bytes_t b);
            expected_secs.push_back(epoch_seconds_of(b));
        endfunction

        task check_result(input logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            if (expected_secs.size() == 0)
                report($sformatf("epoch_seconds %0d with nothing outstanding", got));
            else
            begin
                want = expected_secs.pop_front();
                if (got !== want)
                    report($sformatf("epoch_seconds got %0d want %0d", got, want));
            end
        endtask
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic                  cfg_data  = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;

    epoch_scoreboard sb = new();

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_cycles  = 0;

    rtc_time_to_epoch_seconds_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 clk = ~clk;

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // receiver: long hold-off when asked, otherwise random stalls
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // handshake values are taken at the falling edge, where they are settled
    initial
    begin : result_monitor
        logic [OUT_W-1:0] got;
        forever
        begin
            @(negedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got = m_tdata;
                @(posedge clk);
                sb.check_result(got);
            end
        end
    end

    function automatic logic [7:0] to_clock_byte(input int v, input bit bin);
        if (bin)
            return v[7:0];
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    function automatic clock_bytes_t pack_bytes(input logic [7:0] sec, input logic [7:0] mnt,
                                                input logic [7:0] hr, input logic [7:0] dom,
                                                input logic [7:0] mon, input logic [7:0] yr,
                                                input logic [7:0] cen);
        clock_bytes_t b;
        b.second  = sec;
        b.minute  = mnt;
        b.hour    = hr;
        b.day     = dom;
        b.month   = mon;
        b.year    = yr;
        b.century = cen;
        return b;
    endfunction

    function automatic logic [7:0] corner_byte();
        case ($urandom_range(5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            4:       return 8'h99;
            default: return 8'h12;
        endcase
    endfunction

    function automatic clock_bytes_t random_item(input bit bin, input bit h24);
        clock_bytes_t b;
        int           pick;
        int           hr;
        pick = $urandom_range(99);
        if (pick < 15)
            b = pack_bytes(8'($urandom_range(255)), 8'($urandom_range(255)),
                           8'($urandom_range(255)), 8'($urandom_range(255)),
                           8'($urandom_range(255)), 8'($urandom_range(255)),
                           8'($urandom_range(255)));
        else if (pick < 22)
            b = pack_bytes(corner_byte(), corner_byte(), corner_byte(), corner_byte(),
                           corner_byte(), corner_byte(), corner_byte());
        else
        begin
            b = pack_bytes(to_clock_byte($urandom_range(59), bin),
                           to_clock_byte($urandom_range(59), bin),
                           8'h00,
                           to_clock_byte($urandom_range(1, 31), bin),
                           to_clock_byte($urandom_range(1, 12), bin),
                           to_clock_byte($urandom_range(99), bin),
                           to_clock_byte($urandom_range(19, 21), bin));
            if (h24)
                b.hour = to_clock_byte($urandom_range(23), bin);
            else
            begin
                hr = $urandom_range(1, 12);
                b.hour = to_clock_byte(hr, bin) | {$urandom_range(1) == 1, 7'b0};
            end
        end
        return b;
    endfunction

    task send_item(input clock_bytes_t b);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        sb.note_item(b);
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task drain_results();
        s_tvalid <= 1'b0;
        while (sb.expected_secs.size() != 0)
            @(posedge clk);
    endtask

    task cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // only called with nothing in flight
    task set_mode(input bit bin, input bit h24);
        cfg_write(CFG_BINARY_DATA, bin);
        sb.binary_mode = bin;
        cfg_write(CFG_HOUR_24, h24);
        sb.hour_24_mode = h24;
        cfg_valid <= 1'b0;
    endtask

    task directed_items(input bit bin, input bit h24);
        // year zero, day zero, month zero, all nibbles clear
        send_item(pack_bytes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_item(pack_bytes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        // start of the epoch, midnight written as 12 am in 12-hour mode
        send_item(pack_bytes(8'h00, 8'h00, h24 ? 8'h00 : to_clock_byte(12, bin),
                             to_clock_byte(1, bin), to_clock_byte(1, bin),
                             to_clock_byte(70, bin), to_clock_byte(19, bin)));
        // noon with pm flag, 59:59 past the hour on the last day of 2099
        send_item(pack_bytes(to_clock_byte(59, bin), to_clock_byte(59, bin),
                             to_clock_byte(12, bin) | 8'h80, to_clock_byte(31, bin),
                             to_clock_byte(12, bin), to_clock_byte(99, bin),
                             to_clock_byte(20, bin)));
        // month above twelve in a 400-year leap year, 11 pm
        send_item(pack_bytes(8'h00, 8'h00, to_clock_byte(11, bin) | 8'h80,
                             to_clock_byte(29, bin), to_clock_byte(13, bin),
                             8'h00, to_clock_byte(20, bin)));
        // feb 29 of a non-leap century, digits above nine, hour byte with bit 7 clear
        send_item(pack_bytes(8'hAF, 8'hFA, 8'h7F, to_clock_byte(29, bin),
                             to_clock_byte(2, bin), 8'h00, to_clock_byte(21, bin)));
    endtask

    initial
    begin
        bit phase_bin;
        bit phase_h24;
        int waited;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int p = 0; p < 8; p++)
        begin
            drain_results();
            case (p)
                0:       begin phase_bin = 0; phase_h24 = 1; tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin phase_bin = 1; phase_h24 = 1; tx_idle_pct = 55; rx_stall_pct = 0;  end
                2:       begin phase_bin = 0; phase_h24 = 0; tx_idle_pct = 0;  rx_stall_pct = 55; end
                3:       begin phase_bin = 1; phase_h24 = 0; tx_idle_pct = 20; rx_stall_pct = 20; end
                4:       begin phase_bin = 0; phase_h24 = 1; tx_idle_pct = 0;  rx_stall_pct = 0;  end
                5:       begin phase_bin = 0; phase_h24 = 0; tx_idle_pct = 55; rx_stall_pct = 0;  end
                6:       begin phase_bin = 1; phase_h24 = 1; tx_idle_pct = 0;  rx_stall_pct = 55; end
                default: begin phase_bin = 1; phase_h24 = 0; tx_idle_pct = 20; rx_stall_pct = 20; end
            endcase
            set_mode(phase_bin, phase_h24);
            // receiver blocked while the sender keeps offering items
            if (p == 4)
                hold_cycles = 300;
            if (p < 4)
                directed_items(phase_bin, phase_h24);
            for (int i = 0; i < 90; i++)
            begin
                if (p == 6 && i == 45)
                    drain_results();
                send_item(random_item(phase_bin, phase_h24));
            end
        end
        s_tvalid <= 1'b0;
        waited = 0;
        while (sb.expected_secs.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (sb.expected_secs.size() != 0)
            sb.report($sformatf("%0d epoch_seconds items never arrived",
                                sb.expected_secs.size()));
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> rtc_time_to_epoch_seconds_core.f
hdl/rte_pkg.sv
hdl/rtc_time_to_epoch_seconds_core.sv
test/tb_rtc_time_to_epoch_seconds_core.sv
